// ===== hdl/pn2d_pkg.sv =====
// package for the 2d gradient noise core: formats, permutation rom, gradient select
`timescale 1ns / 1ps
package pn2d_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int INT_BITS   = 16;
  localparam int COORD_BITS = INT_BITS + FRAC_BITS;
  localparam int OUT_BITS   = FRAC_BITS + 1;
  // working width for signed q values
  localparam int QW         = FRAC_BITS + 6;

  typedef logic signed [QW-1:0] q_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  function automatic q_t grad_dot(input logic [3:0] h, input q_t dx, input q_t dy);
    q_t u, v;
    u = (h < 4'd8) ? dx : dy;
    v = (h < 4'd4) ? dy : ((h == 4'd12 || h == 4'd14) ? dx : '0);
    grad_dot = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // q product, floor back to FRAC_BITS fraction bits
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    qmul = q_t'(p >>> FRAC_BITS);
  endfunction
endpackage

// ===== hdl/perlin_noise_2d_core.sv =====
// top level of the 2d gradient noise core
// throughput: one request per clock; a stall freezes every stage together
// eight stages: slice, fade products over three stages with the rom lookups, corner dots,
// row lerps, column lerp, map and saturate
// reset: synchronous active-low rst_n clears valid bits and seed to 0
`timescale 1ns / 1ps
module perlin_noise_2d_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  output logic out_valid,
  input  logic out_ready,
  output logic [pn2d_pkg::OUT_BITS-1:0] out_noise_value,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_seed_byte
);
  import pn2d_pkg::*;
  localparam int NS = 8;

  logic [7:0] seed_r;
  logic [NS-1:0] vld_r;
  logic adv;

  // stage payloads
  q_t xf_r [4], yf_r [4];
  q_t tx_r, ty_r, t2x_r, t2y_r, ix_r, iy_r, t3x_r, t3y_r;
  q_t u_r, v_r, v2_r, v3_r;
  logic [7:0] xi_r [2], yi_r [2];
  logic [7:0] px0_r, px1_r, yb_r;
  logic [3:0] h00_r, h01_r, h10_r, h11_r;
  q_t r0_r, r1_r, d00_r, d01_r, d10_r, d11_r, n_r, u5_r;
  logic [OUT_BITS-1:0] res_r;

  assign adv = !vld_r[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[NS-1];
  assign out_noise_value = res_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      vld_r <= '0;
    end else begin
      if (cfg_valid) seed_r <= cfg_seed_byte;
      if (adv) vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  function automatic logic [7:0] hsh(input logic [7:0] i, input logic [7:0] s);
    hsh = PERM_ROM[i] ^ s;
  endfunction

  function automatic q_t lerp_sub(input q_t a, input q_t b);
    lerp_sub = b - a;
  endfunction

  q_t one_q;
  assign one_q = q_t'(1) <<< FRAC_BITS;

  function automatic logic [OUT_BITS-1:0] sat_out(input q_t n);
    q_t r;
    r = (n >>> 1) + (q_t'(1) <<< (FRAC_BITS-1));
    if (r < 0) sat_out = '0;
    else if (r > one_q) sat_out = OUT_BITS'(one_q);
    else sat_out = OUT_BITS'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      // s0: slice
      xf_r[0] <= q_t'({1'b0, in_x_coord[FRAC_BITS-1:0]});
      yf_r[0] <= q_t'({1'b0, in_y_coord[FRAC_BITS-1:0]});
      xi_r[0] <= in_x_coord[FRAC_BITS+7:FRAC_BITS];
      yi_r[0] <= in_y_coord[FRAC_BITS+7:FRAC_BITS];
      for (int i = 1; i < 4; i++) begin
        xf_r[i] <= xf_r[i-1];
        yf_r[i] <= yf_r[i-1];
      end
      // s1: t*t and 6t-15
      t2x_r <= qmul(xf_r[0], xf_r[0]);
      t2y_r <= qmul(yf_r[0], yf_r[0]);
      tx_r <= q_t'(6) * xf_r[0] - q_t'(15) * one_q;
      ty_r <= q_t'(6) * yf_r[0] - q_t'(15) * one_q;
      xi_r[1] <= xi_r[0];
      yi_r[1] <= yi_r[0];
      // s2: t^3, t*(6t-15)+10; first hash level
      t3x_r <= qmul(t2x_r, xf_r[1]);
      t3y_r <= qmul(t2y_r, yf_r[1]);
      ix_r <= qmul(xf_r[1], tx_r) + q_t'(10) * one_q;
      iy_r <= qmul(yf_r[1], ty_r) + q_t'(10) * one_q;
      px0_r <= hsh(xi_r[1], seed_r);
      px1_r <= hsh(xi_r[1] + 8'd1, seed_r);
      yb_r <= yi_r[1];
      // s3: fades; corner hashes
      u_r <= qmul(t3x_r, ix_r);
      v_r <= qmul(t3y_r, iy_r);
      h00_r <= 4'(hsh(px0_r + yb_r, seed_r));
      h01_r <= 4'(hsh(px0_r + yb_r + 8'd1, seed_r));
      h10_r <= 4'(hsh(px1_r + yb_r, seed_r));
      h11_r <= 4'(hsh(px1_r + yb_r + 8'd1, seed_r));
      // s4: corner dots
      d00_r <= grad_dot(h00_r, xf_r[3], yf_r[3]);
      d10_r <= grad_dot(h10_r, xf_r[3] - one_q, yf_r[3]);
      d01_r <= grad_dot(h01_r, xf_r[3], yf_r[3] - one_q);
      d11_r <= grad_dot(h11_r, xf_r[3] - one_q, yf_r[3] - one_q);
      u5_r <= u_r;
      v2_r <= v_r;
      // s5: row blends
      r0_r <= d00_r + qmul(u5_r, lerp_sub(d00_r, d10_r));
      r1_r <= d01_r + qmul(u5_r, lerp_sub(d01_r, d11_r));
      v3_r <= v2_r;
      // s6: column blend
      n_r <= r0_r + qmul(v3_r, lerp_sub(r0_r, r1_r));
      // s7: map and saturate
      res_r <= sat_out(n_r);
    end
  end
endmodule

// ===== hdl/pn2d_checker.sv =====
// port-level checker for the noise core, bound to the top level
`timescale 1ns / 1ps
module pn2d_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [pn2d_pkg::OUT_BITS-1:0] out_noise_value
);
  import pn2d_pkg::*;
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_noise_value <= OUT_BITS'(1 << FRAC_BITS)) else $error("range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value)) else $error("hold");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("ready");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("stall");
endmodule

bind perlin_noise_2d_core pn2d_checker u_pn2d_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_noise_value(out_noise_value)
);

// ===== tb/tb.sv =====
// testbench for the 2d gradient noise core: self-checking against a local noise predictor
`timescale 1ns / 1ps
module tb;
  import pn2d_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_x_coord;
  logic signed [31:0] in_y_coord;
  logic out_valid;
  logic out_ready;
  logic [OUT_BITS-1:0] out_noise_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_seed_byte;

  logic [7:0] seed_shadow;
  logic [OUT_BITS-1:0] noise_expected_q[$];
  int fail_count = 0;
  int send_idle_pct;
  int recv_stall_pct;

  perlin_noise_2d_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_noise_value(out_noise_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_seed_byte(cfg_seed_byte)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("** perlin_noise_2d_core: FAILED **");
    $finish;
  end

  // floor division by 2^sh on 64-bit signed values
  function automatic longint floor_sh(input longint p, input int sh);
    floor_sh = p >>> sh;
  endfunction

  function automatic longint fix_mul(input longint a, input longint b);
    fix_mul = floor_sh(a * b, FRAC_BITS);
  endfunction

  function automatic longint quintic(input longint t);
    longint t3, inner;
    t3 = fix_mul(fix_mul(t, t), t);
    inner = fix_mul(t, 6 * t - 15 * 65536) + 10 * 65536;
    quintic = fix_mul(t3, inner);
  endfunction

  function automatic longint lerp_fix(input longint a, input longint b, input longint t);
    lerp_fix = a + fix_mul(t, b - a);
  endfunction

  function automatic longint gradient(input logic [3:0] h, input longint dx, input longint dy);
    longint u, v;
    u = (h < 8) ? dx : dy;
    v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : 0);
    gradient = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] perm_hash(input logic [7:0] idx);
    perm_hash = PERM_ROM[idx] ^ seed_shadow;
  endfunction

  function automatic logic [OUT_BITS-1:0] noise_at(input logic [31:0] xc, input logic [31:0] yc);
    logic [7:0] xi, yi, px0, px1, h00, h01, h10, h11;
    longint xf, yf, u, v, r0, r1, n, r;
    xi = xc[23:16];
    yi = yc[23:16];
    xf = xc[15:0];
    yf = yc[15:0];
    u = quintic(xf);
    v = quintic(yf);
    px0 = perm_hash(xi);
    px1 = perm_hash(xi + 8'd1);
    h00 = perm_hash(px0 + yi);
    h01 = perm_hash(px0 + yi + 8'd1);
    h10 = perm_hash(px1 + yi);
    h11 = perm_hash(px1 + yi + 8'd1);
    r0 = lerp_fix(gradient(h00[3:0], xf, yf), gradient(h10[3:0], xf - 65536, yf), u);
    r1 = lerp_fix(gradient(h01[3:0], xf, yf - 65536),
                  gradient(h11[3:0], xf - 65536, yf - 65536), u);
    n = lerp_fix(r0, r1, v);
    r = floor_sh(n, 1) + 32768;
    if (r < 0) r = 0;
    if (r > 65536) r = 65536;
    noise_at = r[OUT_BITS-1:0];
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (noise_expected_q.size() == 0) begin
          $error("noise_value: unexpected result %0d", out_noise_value);
          fail_count++;
        end else begin
          logic [OUT_BITS-1:0] exp_v;
          exp_v = noise_expected_q.pop_front();
          if (exp_v !== out_noise_value) begin
            $error("noise_value: expected %0d actual %0d", exp_v, out_noise_value);
            fail_count++;
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays up after the request is taken until the next idle cycle or drain
  task automatic send_point(input logic [31:0] xc, input logic [31:0] yc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= xc;
    in_y_coord <= yc;
    noise_expected_q.push_back(noise_at(xc, yc));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (noise_expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_seed(input logic [7:0] s);
    drain();
    cfg_valid <= 1'b1;
    cfg_seed_byte <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seed_shadow = s;
  endtask

  task automatic test_directed;
    logic [31:0] pts[10];
    pts = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF,
            32'h00FF_8000, 32'hFF00_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA};
    foreach (pts[i]) begin
      send_point(pts[i], pts[(i + 3) % 10]);
      send_point(pts[i], pts[i]);
    end
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        send_point($urandom, $urandom);
      else
        send_point({{8{1'($urandom_range(1))}}, 8'($urandom), 16'($urandom)},
                   {$urandom_range(255) == 0 ? 8'hFF : 8'h00, 8'($urandom), 16'($urandom)});
    end
  endtask

  task automatic test_seeds;
    logic [7:0] seeds[4];
    seeds = '{8'hFF, 8'hA5, 8'h5A, 8'h00};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      test_random(60);
    end
  endtask

  task automatic test_idling;
    int phase_idle[4], phase_stall[4];
    phase_idle = '{0, 48, 0, 10};
    phase_stall = '{0, 0, 48, 10};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      write_seed(8'($urandom));
      test_random(340);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_coord = '0;
    in_y_coord = '0;
    cfg_valid = 1'b0;
    cfg_seed_byte = '0;
    seed_shadow = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_seeds();
    test_idling();
    drain();
    if (fail_count == 0 && noise_expected_q.size() == 0)
      $display("** perlin_noise_2d_core: PASSED **");
    else
      $display("** perlin_noise_2d_core: FAILED **");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/pn2d_pkg.sv
hdl/perlin_noise_2d_core.sv
hdl/pn2d_checker.sv
tb/tb.sv
